// File: sv/vector_line_segmenter_top_defines.svh
// Assertion macros for the vector line segmenter.
// No dependencies; included by the top level.
`ifndef VECTOR_LINE_SEGMENTER_TOP_DEFINES_SVH
`define VECTOR_LINE_SEGMENTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define VLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define VLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/vls_pkg.sv
// Package of the vector line segmenter: widths, codes and the
// controller/datapath command and status structs. No dependencies.
package vls_pkg;

    localparam int COORD_BITS = 12;
    localparam int CMAX       = (1 << COORD_BITS) - 1;
    localparam int MID        = CMAX / 2;
    localparam int N_MAX      = 8;
    localparam int N_BITS     = $clog2(N_MAX + 1);
    localparam int DIV_W      = COORD_BITS + 3;
    localparam int DIV_ITERS  = (DIV_W + 1) / 2;
    localparam int DIV_PW     = 2 * DIV_ITERS;
    localparam int ITER_W     = $clog2(DIV_ITERS);

    localparam logic OP_DOT    = 1'b0;
    localparam logic OP_LINE   = 1'b1;
    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [N_BITS-1:0]     t_count;

    typedef struct packed {
        logic load;
        logic delta;
        logic count;
        logic div_load;
        logic div_step;
        logic code;
        logic emit_move;
        logic emit_draw;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic   op;
        logic   need_move;
        logic   n_zero;
        t_count n;
        logic   out_free;
    } t_stat;

endpackage

// File: sv/vls_in_if.sv
// Request channel of the vector line segmenter: valid, ready, op and points.
// Depends on vls_pkg.
interface vls_in_if;
    import vls_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    t_coord x1;
    t_coord y1;
    t_coord x2;
    t_coord y2;

    modport source (output valid, output op, output x1, output y1, output x2, output y2,
                    input ready);
    modport sink   (input valid, input op, input x1, input y1, input x2, input y2,
                    output ready);
endinterface

// File: sv/vls_out_if.sv
// Command channel of the vector line segmenter: valid, ready, kind, codes, last.
// Depends on vls_pkg.
interface vls_out_if;
    import vls_pkg::*;

    logic   valid;
    logic   ready;
    logic   kind;
    t_coord x_code;
    t_coord y_code;
    logic   last;

    modport source (output valid, output kind, output x_code, output y_code, output last,
                    input ready);
    modport sink   (input valid, input kind, input x_code, input y_code, input last,
                    output ready);
endinterface

// File: sv/vls_ctrl.sv
// Controller of the vector line segmenter: sequences accept, delta, count,
// divide, code and emit steps. Depends on vls_pkg.
module vls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  vls_pkg::t_stat i_stat,
    output vls_pkg::t_cmd  o_cmd
);
    import vls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_COUNT,
        S_LOAD,
        S_DIV,
        S_CODE,
        S_MOVE,
        S_DRAW
    } t_state;

    t_state              r_state, n_state;
    logic [ITER_W-1:0]   r_iter, n_iter;
    t_count              r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_iter     = r_iter;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MOVE;
                end
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state     = S_COUNT;
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.n_zero) begin
                    n_state = S_MOVE;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_iter         = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(DIV_ITERS - 1)) begin
                    n_state = S_CODE;
                end
            end
            S_CODE: begin
                o_cmd.code = 1'b1;
                n_state    = S_MOVE;
            end
            S_MOVE: begin
                if (!i_stat.need_move) begin
                    n_state = i_stat.n_zero ? S_IDLE : S_DRAW;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_move = 1'b1;
                    o_cmd.last      = i_stat.n_zero;
                    n_state         = i_stat.n_zero ? S_IDLE : S_DRAW;
                end
            end
            S_DRAW: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_draw = 1'b1;
                    o_cmd.last      = (r_cnt == i_stat.n - N_BITS'(1));
                    n_cnt           = r_cnt + N_BITS'(1);
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_IDLE && i_in_valid && i_stat.op == OP_LINE) begin
            n_state = S_DELTA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_cnt   <= n_cnt;
        end
    end
endmodule

// File: sv/vls_dp.sv
// Datapath of the vector line segmenter: beam state, deltas, segment count,
// radix-4 divider, code clamp and output register. Depends on vls_pkg.
module vls_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op,
    input  vls_pkg::t_coord i_x1,
    input  vls_pkg::t_coord i_y1,
    input  vls_pkg::t_coord i_x2,
    input  vls_pkg::t_coord i_y2,
    input  vls_pkg::t_cmd  i_cmd,
    output vls_pkg::t_stat o_stat,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output vls_pkg::t_coord o_x_code,
    output vls_pkg::t_coord o_y_code,
    output logic           o_last
);
    import vls_pkg::*;

    typedef struct packed {
        t_count       rem;
        logic [1:0]   q;
    } t_div2;

    function automatic t_div2 div2(input t_count rem, input logic [1:0] b, input t_count d);
        logic [N_BITS:0] t;
        t_count          r;
        t_div2           res;
        t = {rem, b[1]};
        if (t >= {1'b0, d}) begin
            res.q[1] = 1'b1;
            r        = N_BITS'(t - {1'b0, d});
        end else begin
            res.q[1] = 1'b0;
            r        = t[N_BITS-1:0];
        end
        t = {r, b[0]};
        if (t >= {1'b0, d}) begin
            res.q[0] = 1'b1;
            r        = N_BITS'(t - {1'b0, d});
        end else begin
            res.q[0] = 1'b0;
            r        = t[N_BITS-1:0];
        end
        res.rem = r;
        return res;
    endfunction

    function automatic t_coord clamp_code(input logic [DIV_PW-1:0] quo, input logic neg);
        logic signed [DIV_PW+1:0] q;
        logic signed [DIV_PW+1:0] v;
        t_coord                   c;
        q = $signed({2'b00, quo});
        v = $signed((DIV_PW + 2)'(MID)) + (neg ? -q : q);
        if (v < 0) begin
            c = '0;
        end else if (v > $signed((DIV_PW + 2)'(CMAX))) begin
            c = COORD_BITS'(CMAX);
        end else begin
            c = v[COORD_BITS-1:0];
        end
        return c;
    endfunction

    t_coord            r_beam_x, r_beam_y;
    logic              r_known;
    logic              r_op, r_need_move;
    t_coord            r_sx, r_sy, r_ex, r_ey;
    t_coord            r_ax, r_ay;
    logic              r_negx, r_negy;
    t_count            r_n;
    logic [DIV_PW-1:0] r_qx, r_qy;
    t_count            r_remx, r_remy;
    t_coord            r_code_x, r_code_y;
    logic              r_ov, r_okind, r_olast;
    t_coord            r_ox, r_oy;

    logic              at_p1, at_p2, swap;
    logic signed [COORD_BITS:0] dx, dy;
    t_coord            m;
    logic [COORD_BITS+2:0] m8;
    t_count            n_cnt;
    logic [DIV_W-1:0]  dvx, dvy;
    t_div2             stx, sty;
    logic              out_free;

    always_comb begin
        at_p1 = r_known && r_beam_x == i_x1 && r_beam_y == i_y1;
        at_p2 = r_known && r_beam_x == i_x2 && r_beam_y == i_y2;
        swap  = (i_op == OP_LINE) && at_p2;

        dx = $signed({1'b0, r_ex}) - $signed({1'b0, r_sx});
        dy = $signed({1'b0, r_ey}) - $signed({1'b0, r_sy});

        m     = (r_ax > r_ay) ? r_ax : r_ay;
        m8    = {m, 3'b000};
        n_cnt = '0;
        for (int k = 0; k < N_MAX; k++) begin
            if (m8 > (COORD_BITS + 3)'(k * CMAX)) begin
                n_cnt = n_cnt + N_BITS'(1);
            end
        end

        dvx = {1'b0, r_ax, 2'b00} + (r_negx ? '0 : DIV_W'(r_n - N_BITS'(1)));
        dvy = {1'b0, r_ay, 2'b00} + (r_negy ? '0 : DIV_W'(r_n - N_BITS'(1)));

        stx = div2(r_remx, r_qx[DIV_PW-1 -: 2], r_n);
        sty = div2(r_remy, r_qy[DIV_PW-1 -: 2], r_n);

        out_free = !r_ov || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_x <= '0;
            r_beam_y <= '0;
            r_known  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_known <= 1'b1;
                if (i_op == OP_LINE && !swap) begin
                    r_beam_x <= i_x2;
                    r_beam_y <= i_y2;
                end else begin
                    r_beam_x <= i_x1;
                    r_beam_y <= i_y1;
                end
            end
            if (i_cmd.emit_move || i_cmd.emit_draw) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_op;
            r_need_move <= !(at_p1 || swap);
            r_sx        <= swap ? i_x2 : i_x1;
            r_sy        <= swap ? i_y2 : i_y1;
            r_ex        <= swap ? i_x1 : i_x2;
            r_ey        <= swap ? i_y1 : i_y2;
            r_n         <= N_BITS'(1);
            r_code_x    <= COORD_BITS'(MID);
            r_code_y    <= COORD_BITS'(MID);
        end
        if (i_cmd.delta) begin
            r_negx <= dx[COORD_BITS];
            r_negy <= dy[COORD_BITS];
            r_ax   <= dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
            r_ay   <= dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        end
        if (i_cmd.count) begin
            r_n <= n_cnt;
        end
        if (i_cmd.div_load) begin
            r_qx   <= DIV_PW'(dvx);
            r_qy   <= DIV_PW'(dvy);
            r_remx <= '0;
            r_remy <= '0;
        end
        if (i_cmd.div_step) begin
            r_qx   <= {r_qx[DIV_PW-3:0], stx.q};
            r_qy   <= {r_qy[DIV_PW-3:0], sty.q};
            r_remx <= stx.rem;
            r_remy <= sty.rem;
        end
        if (i_cmd.code) begin
            r_code_x <= clamp_code(r_qx, r_negx);
            r_code_y <= clamp_code(r_qy, r_negy);
        end
        if (i_cmd.emit_move) begin
            r_okind <= KIND_MOVE;
            r_ox    <= r_sx;
            r_oy    <= r_sy;
            r_olast <= i_cmd.last;
        end
        if (i_cmd.emit_draw) begin
            r_okind <= KIND_DRAW;
            r_ox    <= r_code_x;
            r_oy    <= r_code_y;
            r_olast <= i_cmd.last;
        end
    end

    assign o_stat.op        = (i_cmd.load) ? i_op : r_op;
    assign o_stat.need_move = r_need_move;
    assign o_stat.n_zero    = (r_n == '0);
    assign o_stat.n         = r_n;
    assign o_stat.out_free  = out_free;

    assign o_valid  = r_ov;
    assign o_kind   = r_okind;
    assign o_x_code = r_ox;
    assign o_y_code = r_oy;
    assign o_last   = r_olast;
endmodule

// File: sv/vector_line_segmenter_top.sv
// Vector line segmenter: takes one dot or line request at a time and emits
// move and draw commands. A dot is accepted, then its move is checked or sent,
// then it draws. A line is accepted, then passes the delta, count, load,
// divider and code steps, the move slot (whether or not a move goes out) and
// one to eight draws; a zero-length line skips the divider and code steps and
// ends after the move slot. The radix-4 divider forms the per-draw code.
// A request is taken only when the previous one has handed its last command
// to the output register, which may still wait on the sink. An output stall
// holds the controller in its move or draw step.
`include "vector_line_segmenter_top_defines.svh"

module vector_line_segmenter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vls_in_if.sink    i_req,
    vls_out_if.source o_cmd
);
    import vls_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    vls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vls_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (i_req.op),
        .i_x1     (i_req.x1),
        .i_y1     (i_req.y1),
        .i_x2     (i_req.x2),
        .i_y2     (i_req.y2),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_cmd.valid),
        .i_ready  (o_cmd.ready),
        .o_kind   (o_cmd.kind),
        .o_x_code (o_cmd.x_code),
        .o_y_code (o_cmd.y_code),
        .o_last   (o_cmd.last)
    );

    `VLS_ASSERT_IMPL(a_move_needed, i_clk, i_rst_n, cmd.emit_move, stat.need_move, "bad move")
    `VLS_ASSERT_NEXT(a_busy_after_load, i_clk, i_rst_n, cmd.load, !i_req.ready, "taken busy")
    `VLS_ASSERT_IMPL(a_dot_last, i_clk, i_rst_n, cmd.emit_draw && (stat.op == OP_DOT), cmd.last, "dot last")
endmodule
